// File: rtl/core/bslp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslp_pkg
// Types and codes shared by the short/long press classifier.
// ----------------------------------------------------------------------------
package bslp_pkg;

  localparam int COUNT_WIDTH_DEF = 8;
  localparam int CFG_WIDTH       = 8;
  localparam int CFG_IDX_WIDTH   = 1;

  // register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_LONG_PRESS = 1'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_DEBOUNCE   = 1'd1;

  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RST = 8'd5;
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST   = 8'd0;

  // item modes
  localparam logic MODE_TICK = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // phases
  localparam logic [1:0] PH_WAIT     = 2'd0;
  localparam logic [1:0] PH_PRESSED  = 2'd1;
  localparam logic [1:0] PH_LONG     = 2'd2;
  localparam logic [1:0] PH_DEBOUNCE = 2'd3;

  // event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_SHORT = 2'd1;
  localparam logic [1:0] EV_LONG  = 2'd2;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] long_press_ticks;
    logic [CFG_WIDTH-1:0] debounce_ticks;
  } cfg_t;

  typedef struct packed {
    logic mode;
    logic pin_level;
  } item_t;

  typedef struct packed {
    logic [1:0] event_code;
    logic [1:0] phase;
  } result_t;

endpackage

// File: rtl/core/bslp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslp_in_if
// Input channel: tick or read items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bslp_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic pin_level;

  modport source (output valid, output mode, output pin_level, input ready);
  modport sink   (input valid, input mode, input pin_level, output ready);
endinterface

// File: rtl/core/bslp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslp_out_if
// Result channel: event code and phase with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bslp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic [1:0] phase;

  modport source (output valid, output event_code, output phase, input ready);
  modport sink   (input valid, input event_code, input phase, output ready);
endinterface

// File: rtl/core/bslp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslp_cfg_regs
// Configuration registers for long-press and debounce tick counts.
// ----------------------------------------------------------------------------
module bslp_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [bslp_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [bslp_pkg::CFG_WIDTH-1:0]       cfg_wdata,
  output bslp_pkg::cfg_t                       cfg
);

  bslp_pkg::cfg_t cfg_r;
  bslp_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        bslp_pkg::CFG_IDX_LONG_PRESS: cfg_nxt.long_press_ticks = cfg_wdata;
        bslp_pkg::CFG_IDX_DEBOUNCE:   cfg_nxt.debounce_ticks   = cfg_wdata;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks <= bslp_pkg::LONG_PRESS_RST;
      cfg_r.debounce_ticks   <= bslp_pkg::DEBOUNCE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/core/bslp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslp_step
// Phase, tick counter and pending event; one item processed per fire.
// ----------------------------------------------------------------------------
module bslp_step #(
  parameter int COUNT_WIDTH = bslp_pkg::COUNT_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  bslp_pkg::item_t   item,
  input  bslp_pkg::cfg_t    cfg,
  output bslp_pkg::result_t result
);

  logic [1:0]             phase_r;
  logic [1:0]             phase_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r;
  logic [COUNT_WIDTH-1:0] cnt_nxt;
  logic [1:0]             pend_r;
  logic [1:0]             pend_nxt;
  logic [COUNT_WIDTH-1:0] long_load;
  logic [COUNT_WIDTH-1:0] deb_load;
  logic                   cnt_zero;
  logic                   released;

  assign long_load = COUNT_WIDTH'(cfg.long_press_ticks);
  assign deb_load  = COUNT_WIDTH'(cfg.debounce_ticks);
  assign cnt_zero  = (cnt_r == '0);
  assign released  = item.pin_level;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    if (item.mode == bslp_pkg::MODE_READ) begin
      pend_nxt = bslp_pkg::EV_NONE;
    end else begin
      case (phase_r)
        bslp_pkg::PH_WAIT: begin
          // press only taken while nothing is pending
          if (pend_r == bslp_pkg::EV_NONE && !released) begin
            cnt_nxt   = long_load;
            phase_nxt = bslp_pkg::PH_PRESSED;
          end
        end
        bslp_pkg::PH_PRESSED: begin
          if (released) begin
            phase_nxt = bslp_pkg::PH_DEBOUNCE;
            cnt_nxt   = deb_load;
            pend_nxt  = bslp_pkg::EV_SHORT;
          end else if (cnt_zero) begin
            phase_nxt = bslp_pkg::PH_LONG;
          end else begin
            cnt_nxt = cnt_r - COUNT_WIDTH'(1);
          end
        end
        bslp_pkg::PH_LONG: begin
          if (released) begin
            phase_nxt = bslp_pkg::PH_DEBOUNCE;
            cnt_nxt   = deb_load;
            pend_nxt  = bslp_pkg::EV_LONG;
          end
        end
        default: begin
          if (cnt_zero) begin
            phase_nxt = bslp_pkg::PH_WAIT;
          end else begin
            cnt_nxt = cnt_r - COUNT_WIDTH'(1);
          end
        end
      endcase
    end
  end

  // a read reports the event before its clear, a tick the one after
  always_comb begin
    result.phase      = phase_nxt;
    result.event_code = (item.mode == bslp_pkg::MODE_READ) ? pend_r : pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bslp_pkg::PH_WAIT;
      cnt_r   <= '0;
      pend_r  <= bslp_pkg::EV_NONE;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// File: rtl/core/button_short_long_press_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_short_long_press_top
// Short/long press classifier for an active-low push button.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless stalled: a tick carries one pin sample
// (0 = pressed) and advances the wait/pressed/long/debounce phases, a read
// returns the pending event and clears it. Every item gives exactly one
// result: it is held in the input register, then the phase update writes the
// result register. While a result waits, the input register takes one more
// item and then both sides stall cleanly under backpressure.
// Configuration writes take effect on the next cycle and are expected only
// while no item is in flight.
module button_short_long_press_top #(
  parameter int COUNT_WIDTH = bslp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  bslp_in_if.sink                            in_ch,
  bslp_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [bslp_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [bslp_pkg::CFG_WIDTH-1:0]     cfg_wdata
);

  bslp_pkg::cfg_t    cfg;
  bslp_pkg::item_t   s1_item_r;
  logic              s1_valid_r;
  logic              s1_adv;
  bslp_pkg::result_t step_res;
  bslp_pkg::result_t out_res_r;
  logic              out_valid_r;

  bslp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bslp_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_adv),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (step_res)
  );

  // item moves on when the result register is free or being emptied
  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r.mode      <= in_ch.mode;
      s1_item_r.pin_level <= in_ch.pin_level;
    end
    if (s1_adv) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_code = out_res_r.event_code;
  assign out_ch.phase      = out_res_r.phase;

endmodule

// File: bench/bslp_press_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bslp_press_checker
// Watches the item and result channels of the press classifier, keeps its own
// copy of the phase, count, pending event and thresholds, predicts one result
// per accepted item and compares each accepted result with the oldest one.
// ----------------------------------------------------------------------------
module bslp_press_checker
  import bslp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  bslp_in_if                   in_mon,
  bslp_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_wdata,
  output int                   mismatch_count,
  output int                   results_owed
);

  logic [1:0]                 press_phase;
  logic [COUNT_WIDTH_DEF-1:0] hold_count;
  logic [1:0]                 latched_event;
  logic [CFG_WIDTH-1:0]       long_limit;
  logic [CFG_WIDTH-1:0]       debounce_limit;
  result_t                    owed_q[$];
  int                         errors = 0;

  // advances the classifier by one item and returns what the block must report
  function automatic result_t classify_item(item_t it);
    result_t r;
    if (it.mode == MODE_READ) begin
      r.event_code  = latched_event;
      latched_event = EV_NONE;
    end else begin
      case (press_phase)
        PH_WAIT: begin
          // a press is ignored while an event is still waiting to be read
          if (latched_event == EV_NONE && !it.pin_level) begin
            hold_count  = COUNT_WIDTH_DEF'(long_limit);
            press_phase = PH_PRESSED;
          end
        end
        PH_PRESSED: begin
          if (it.pin_level) begin
            press_phase   = PH_DEBOUNCE;
            hold_count    = COUNT_WIDTH_DEF'(debounce_limit);
            latched_event = EV_SHORT;
          end else if (hold_count == '0) begin
            press_phase = PH_LONG;
          end else begin
            hold_count = hold_count - 1'b1;
          end
        end
        PH_LONG: begin
          if (it.pin_level) begin
            press_phase   = PH_DEBOUNCE;
            hold_count    = COUNT_WIDTH_DEF'(debounce_limit);
            latched_event = EV_LONG;
          end
        end
        default: begin
          if (hold_count == '0) begin
            press_phase = PH_WAIT;
          end else begin
            hold_count = hold_count - 1'b1;
          end
        end
      endcase
      r.event_code = latched_event;
    end
    r.phase = press_phase;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    result_t got;
    item_t   taken;
    if (!rst_n) begin
      press_phase    = PH_WAIT;
      hold_count     = '0;
      latched_event  = EV_NONE;
      long_limit     = LONG_PRESS_RST;
      debounce_limit = DEBOUNCE_RST;
      owed_q.delete();
    end else begin
      // results first, so a result with nothing owed is never hidden by this edge's item
      if (out_mon.valid && out_mon.ready) begin
        got.event_code = out_mon.event_code;
        got.phase      = out_mon.phase;
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual event_code %0d phase %0d",
                   $time, got.event_code, got.phase);
          errors++;
        end else begin
          want = owed_q.pop_front();
          if (got.event_code !== want.event_code) begin
            $display("%0t: event_code mismatch: expected %0d, actual %0d",
                     $time, want.event_code, got.event_code);
            errors++;
          end
          if (got.phase !== want.phase) begin
            $display("%0t: phase mismatch: expected %0d, actual %0d",
                     $time, want.phase, got.phase);
            errors++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        taken.mode      = in_mon.mode;
        taken.pin_level = in_mon.pin_level;
        owed_q.push_back(classify_item(taken));
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_LONG_PRESS: long_limit     = cfg_wdata;
          CFG_IDX_DEBOUNCE:   debounce_limit = cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatch_count <= errors;
    results_owed   <= owed_q.size();
  end

endmodule

// File: bench/tb_button_short_long_press_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_short_long_press_top
// Drives press/release tick sequences and reads into the classifier under
// several threshold settings, with random idling on both channels and one
// long result stall; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_button_short_long_press_top;
  import bslp_pkg::*;

  localparam logic PIN_PRESSED    = 1'b0;
  localparam logic PIN_RELEASED   = 1'b1;
  localparam int   HOLD_OFF_CYCLES = 400;
  localparam int   DRAIN_CYCLES    = 4;
  localparam int   WATCHDOG_LIMIT  = 3000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_WIDTH-1:0] cfg_index;
  logic [CFG_WIDTH-1:0]     cfg_wdata;

  int   fail_count;
  int   results_owed;
  int   items_sent = 0;
  int   cur_long = 5;
  int   cur_debounce = 0;
  logic no_idle = 1'b0;
  logic hold_off_req = 1'b0;

  bslp_in_if  in_ch ();
  bslp_out_if out_ch ();

  button_short_long_press_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bslp_press_checker press_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (fail_count),
    .results_owed   (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic mode, input logic pin);
    int gap;
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.pin_level <= pin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_noise();
    send_item(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)));
  endtask

  // wait until every owed result is back and the pipeline has gone quiet
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_thresholds(input int long_ticks, input int debounce);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_LONG_PRESS;
    cfg_wdata <= long_ticks[CFG_WIDTH-1:0];
    @(posedge clk);
    cfg_index <= CFG_IDX_DEBOUNCE;
    cfg_wdata <= debounce[CFG_WIDTH-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_long     = long_ticks;
    cur_debounce = debounce;
  endtask

  // one press and release with random hold time, reads and bounce noise mixed in;
  // cut short once the item count reaches end_at
  task automatic press_sequence(input int end_at);
    int hold;
    int rel;
    case ($urandom_range(0, 3))
      0:       hold = $urandom_range(1, cur_long + 1);
      1:       hold = cur_long + 2;
      2:       hold = cur_long + 2 + $urandom_range(1, 6);
      default: hold = $urandom_range(1, cur_long + 4);
    endcase
    rel = $urandom_range(1, cur_debounce + 3);
    repeat (hold) begin
      if (items_sent >= end_at) begin
        return;
      end
      if ($urandom_range(0, 99) < 8) begin
        send_item(MODE_READ, logic'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 99) < 5) begin
        send_noise();
      end
      send_item(MODE_TICK, PIN_PRESSED);
    end
    repeat (rel) begin
      if (items_sent >= end_at) begin
        return;
      end
      if ($urandom_range(0, 99) < 4) begin
        send_noise();
      end
      send_item(MODE_TICK, PIN_RELEASED);
    end
    // leaving the event unread makes the next press get ignored
    if (items_sent < end_at && $urandom_range(0, 99) < 75) begin
      send_item(MODE_READ, logic'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(input int long_ticks, input int debounce, input int budget);
    int start;
    program_thresholds(long_ticks, debounce);
    start = items_sent;
    while (items_sent - start < budget) press_sequence(start + budget);
  endtask

  // result side: random ready with one long hold-off on request
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      gap = idle_gap();
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_TICK;
    in_ch.pin_level = PIN_RELEASED;
    cfg_we          = 1'b0;
    cfg_index       = CFG_IDX_LONG_PRESS;
    cfg_wdata       = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset thresholds: long press after 7 low ticks, no debounce
    send_item(MODE_READ, PIN_RELEASED);
    send_item(MODE_TICK, PIN_RELEASED);
    send_item(MODE_TICK, PIN_PRESSED);
    send_item(MODE_READ, PIN_PRESSED);
    repeat (6) send_item(MODE_TICK, PIN_PRESSED);
    send_item(MODE_TICK, PIN_PRESSED);
    send_item(MODE_TICK, PIN_RELEASED);
    send_item(MODE_TICK, PIN_PRESSED);
    // long event still pending, so this press is dropped
    send_item(MODE_TICK, PIN_PRESSED);
    send_item(MODE_READ, PIN_PRESSED);
    send_item(MODE_READ, PIN_RELEASED);
    send_item(MODE_TICK, PIN_PRESSED);
    send_item(MODE_TICK, PIN_PRESSED);
    send_item(MODE_TICK, PIN_RELEASED);
    send_item(MODE_READ, PIN_RELEASED);
    send_item(MODE_TICK, PIN_RELEASED);

    no_idle = 1'b1;
    run_phase(0, 0, 200);
    no_idle = 1'b0;
    run_phase(255, 255, 350);
    hold_off_req = 1'b1;
    run_phase(1, 3, 200);
    run_phase(0, 255, 150);
    run_phase($urandom_range(0, 12), $urandom_range(0, 12), 200);
    run_phase($urandom_range(0, 12), $urandom_range(0, 12), 200);
    run_phase(5, 0, 150);

    settle_block();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
